### rtl/qth_pkg.sv
// ----------------------------------------------------------------------------
// qth_pkg: shared types and constants for the quaternion heading pipeline
// Payload structs, fixed-point widths, CORDIC angle table and output limits.
// ----------------------------------------------------------------------------
package qth_pkg;

  // Input and result field widths
  localparam int QUAT_W = 16;
  localparam int HEAD_W = 16;

  // Number of CORDIC iterations and the table that bounds it
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int NUM_CELLS       = (CORDIC_STAGES < ANGLE_TABLE_LEN) ?
                                   CORDIC_STAGES : ANGLE_TABLE_LEN;
  localparam int STAGE_W         = 5;

  // Internal widths: Q28 products, Q28 terms, CORDIC vector, Q30 angle
  localparam int PROD_W = 32;
  localparam int TERM_W = 34;
  localparam int XY_W   = 37;
  localparam int Z_W    = 34;
  localparam int MAG_W  = 32;
  localparam int DEGP_W = 46;
  localparam int DSUM_W = 63;

  // Start of the result strobe relative to the accepting edge
  localparam int LATENCY = NUM_CELLS + 6;

  localparam logic signed [TERM_W-1:0] ONE_Q28      = TERM_W'(64'sd268435456);
  localparam logic signed [Z_W-1:0]    PI_Q30       = Z_W'(64'sd3373259426);
  localparam logic [29:0]              RAD_TO_DEG_Q24 = 30'd961263669;
  localparam logic [HEAD_W-1:0]        DEG_LIMIT    = 16'd23040;
  localparam logic [HEAD_W-1:0]        RAD_LIMIT    = 16'd25736;

  // Input transaction: one orientation quaternion, signed Q14 parts
  typedef struct packed {
    logic signed [QUAT_W-1:0] quat_real;
    logic signed [QUAT_W-1:0] quat_i;
    logic signed [QUAT_W-1:0] quat_j;
    logic signed [QUAT_W-1:0] quat_k;
  } quat_t;

  // Result transaction: clockwise-positive yaw
  typedef struct packed {
    logic signed [HEAD_W-1:0] heading_deg;  // Q7 degrees
    logic signed [HEAD_W-1:0] heading_rad;  // Q13 radians
  } heading_t;

  // Vector handed from cell to cell
  typedef struct packed {
    logic                   valid;
    logic                   zero;   // both terms zero: angle forced to 0
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in Q30 radians, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = Z_W'(64'sd843314857);
      5'd1:    a = Z_W'(64'sd497837829);
      5'd2:    a = Z_W'(64'sd263043837);
      5'd3:    a = Z_W'(64'sd133525159);
      5'd4:    a = Z_W'(64'sd67021687);
      5'd5:    a = Z_W'(64'sd33543516);
      5'd6:    a = Z_W'(64'sd16775851);
      5'd7:    a = Z_W'(64'sd8388437);
      5'd8:    a = Z_W'(64'sd4194283);
      5'd9:    a = Z_W'(64'sd2097149);
      5'd10:   a = Z_W'(64'sd1048576);
      5'd11:   a = Z_W'(64'sd524288);
      5'd12:   a = Z_W'(64'sd262144);
      5'd13:   a = Z_W'(64'sd131072);
      5'd14:   a = Z_W'(64'sd65536);
      5'd15:   a = Z_W'(64'sd32768);
      5'd16:   a = Z_W'(64'sd16384);
      5'd17:   a = Z_W'(64'sd8192);
      5'd18:   a = Z_W'(64'sd4096);
      5'd19:   a = Z_W'(64'sd2048);
      5'd20:   a = Z_W'(64'sd1024);
      5'd21:   a = Z_W'(64'sd512);
      5'd22:   a = Z_W'(64'sd256);
      5'd23:   a = Z_W'(64'sd128);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/qth_front.sv
// ----------------------------------------------------------------------------
// qth_front: quaternion to yaw vector
// Forms Y = 2(rk+ij) and X = 1-2(jj+kk) in Q28 over two stages, then folds
// the left half-plane onto the right one by a turn of pi.
// ----------------------------------------------------------------------------
module qth_front import qth_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  quat_t   quat,
  output cordic_t vec
);

  // Stage 1: products
  logic                     v1;
  logic signed [PROD_W-1:0] rk, ij, jj, kk;
  logic signed [PROD_W-1:0] rk_c, ij_c, jj_c, kk_c;

  assign rk_c = quat.quat_real * quat.quat_k;
  assign ij_c = quat.quat_i * quat.quat_j;
  assign jj_c = quat.quat_j * quat.quat_j;
  assign kk_c = quat.quat_k * quat.quat_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    rk <= rk_c;
    ij <= ij_c;
    jj <= jj_c;
    kk <= kk_c;
  end

  // Stage 2: terms
  logic                     v2;
  logic signed [TERM_W-1:0] y_t, x_t;
  logic signed [TERM_W-1:0] y_c, x_c;

  assign y_c = (TERM_W'(rk) + TERM_W'(ij)) <<< 1;
  assign x_c = ONE_Q28 - ((TERM_W'(jj) + TERM_W'(kk)) <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    y_t <= y_c;
    x_t <= x_c;
  end

  // Stage 3: quadrant fold
  logic signed [XY_W-1:0] x_e, y_e;
  cordic_t                vec_next;

  assign x_e = XY_W'(x_t);
  assign y_e = XY_W'(y_t);

  always_comb begin
    vec_next.valid = v2;
    vec_next.zero  = (x_t == '0) && (y_t == '0);
    if (x_t < 0) begin
      vec_next.x = -x_e;
      vec_next.y = -y_e;
      vec_next.z = (y_t >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      vec_next.x = x_e;
      vec_next.y = y_e;
      vec_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec.valid <= 1'b0;
    end else begin
      vec.valid <= vec_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    vec.zero <= vec_next.zero;
    vec.x    <= vec_next.x;
    vec.y    <= vec_next.y;
    vec.z    <= vec_next.z;
  end

endmodule

### rtl/qth_cell.sv
// ----------------------------------------------------------------------------
// qth_cell: one CORDIC vectoring iteration
// Rotates the vector toward the x axis by atan(2^-stage) and accumulates
// the angle; the result is registered for the next cell.
// ----------------------------------------------------------------------------
module qth_cell import qth_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [STAGE_W-1:0] stage,
  input  cordic_t            vec_in,
  output cordic_t            vec_out
);

  logic signed [XY_W-1:0] x, y, dx, dy;
  logic signed [Z_W-1:0]  ang;
  cordic_t                vec_next;

  assign x   = vec_in.x;
  assign y   = vec_in.y;
  assign dx  = y >>> stage;
  assign dy  = x >>> stage;
  assign ang = atan_q30(stage);

  // Rotation direction follows the sign of y
  always_comb begin
    vec_next.valid = vec_in.valid;
    vec_next.zero  = vec_in.zero;
    if (y > 0) begin
      vec_next.x = x + dx;
      vec_next.y = y - dy;
      vec_next.z = vec_in.z + ang;
    end else begin
      vec_next.x = x - dx;
      vec_next.y = y + dy;
      vec_next.z = vec_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else begin
      vec_out.valid <= vec_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_out.zero <= vec_next.zero;
    vec_out.x    <= vec_next.x;
    vec_out.y    <= vec_next.y;
    vec_out.z    <= vec_next.z;
  end

endmodule

### rtl/qth_back.sv
// ----------------------------------------------------------------------------
// qth_back: angle to heading outputs
// Negates the accumulated angle, scales it to Q13 radians and Q7 degrees
// with round-half-away and saturation, and drives the result strobe.
// ----------------------------------------------------------------------------
module qth_back import qth_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cordic_t  vec,
  output logic     done,
  output heading_t heading
);

  // Stage 1: magnitude and sign of the heading (heading = -z)
  logic                   v1, neg1;
  logic [MAG_W-1:0]       mag;
  logic signed [Z_W-1:0]  z_abs;
  logic [MAG_W-1:0]       mag_next;

  assign z_abs = (vec.z < 0) ? -vec.z : vec.z;

  // Anything at or past 2^32 saturates both outputs
  always_comb begin
    if (vec.zero) begin
      mag_next = '0;
    end else if (z_abs[Z_W-1:MAG_W] != '0) begin
      mag_next = '1;
    end else begin
      mag_next = z_abs[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    mag  <= mag_next;
    neg1 <= !vec.zero && (vec.z > 0);
  end

  // Stage 2: radian rounding and split degree products
  logic                v2, neg2;
  logic [DEGP_W-1:0]   p_lo, p_hi, p_lo_c, p_hi_c;
  logic [MAG_W:0]      rad_sum;
  logic [HEAD_W-1:0]   rad_q, rad_mag;

  assign p_lo_c  = mag[15:0] * RAD_TO_DEG_Q24;
  assign p_hi_c  = mag[MAG_W-1:16] * RAD_TO_DEG_Q24;
  assign rad_sum = (MAG_W+1)'(mag) + (MAG_W+1)'(1 << 16);
  assign rad_q   = rad_sum[MAG_W:17];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p_lo    <= p_lo_c;
    p_hi    <= p_hi_c;
    rad_mag <= (rad_q > RAD_LIMIT) ? RAD_LIMIT : rad_q;
    neg2    <= neg1;
  end

  // Stage 3: degree rounding, saturation and sign
  logic [DSUM_W-1:0] deg_sum;
  logic [HEAD_W-1:0] deg_q, deg_mag;

  assign deg_sum = (DSUM_W'(p_hi) << 16) + DSUM_W'(p_lo) + (DSUM_W'(1) << 46);
  assign deg_q   = deg_sum[62:47];
  assign deg_mag = (deg_q > DEG_LIMIT) ? DEG_LIMIT : deg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    heading.heading_deg <= neg2 ? -deg_mag : deg_mag;
    heading.heading_rad <= neg2 ? -rad_mag : rad_mag;
  end

endmodule

### rtl/quaternion_to_heading.sv
// done passes the front registers (products, terms, fold), the register of each
// CORDIC cell and the back registers (magnitude, products, output).
// Throughput: one transaction per clock; busy is never raised and the chain
// of CORDIC cells plus the fixed front and back stages all advance every cycle.
// Reset (synchronous, rst high) clears every valid bit: transactions in flight
// are dropped and done stays low until a new transaction has passed through.
// ----------------------------------------------------------------------------
// quaternion_to_heading: quaternion to clockwise-positive yaw
// Pipelined atan2 of the yaw terms by a row of CORDIC vectoring cells,
// producing heading in Q7 degrees and Q13 radians.
// ----------------------------------------------------------------------------
module quaternion_to_heading import qth_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  quat_t    quat,
  output logic     done,
  output heading_t heading
);

  logic    accept;
  cordic_t chain [NUM_CELLS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Yaw terms and quadrant fold
  qth_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .quat   (quat),
    .vec    (chain[0])
  );

  // Row of CORDIC cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    qth_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .stage   (STAGE_W'(g)),
      .vec_in  (chain[g]),
      .vec_out (chain[g+1])
    );
  end

  // Scaling and output register
  qth_back u_back (
    .clk     (clk),
    .rst     (rst),
    .vec     (chain[NUM_CELLS]),
    .done    (done),
    .heading (heading)
  );

  // Every accepted transaction produces a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  // No result without a transaction accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching transaction");

  // Outputs stay within the saturation limits
  a_limits: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(heading.heading_deg) <= $signed(DEG_LIMIT)) &&
             ($signed(heading.heading_deg) >= -$signed(DEG_LIMIT)) &&
             ($signed(heading.heading_rad) <= $signed(RAD_LIMIT)) &&
             ($signed(heading.heading_rad) >= -$signed(RAD_LIMIT)))
    else $error("heading outside saturation range");

  // A nonzero degree output carries the same sign in radians
  a_sign_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (!($signed(heading.heading_deg) > 0) ||
              ($signed(heading.heading_rad) > 0)) &&
             (!($signed(heading.heading_deg) < 0) ||
              ($signed(heading.heading_rad) < 0)))
    else $error("degree and radian outputs disagree in sign");

endmodule

### dv/quaternion_to_heading_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_heading_tb: self-checking bench for the quaternion heading block
// Feeds directed and random quaternions through a bursty command driver and
// checks every heading strobe against an in-bench CORDIC atan2 predictor.
// ----------------------------------------------------------------------------
module quaternion_to_heading_tb;
  import qth_pkg::*;

  // Predictor constants (Q30 radians, Q24 degrees per radian, output clamps)
  localparam longint HALF_TURN_Q30   = 64'sd3373259426;
  localparam longint DEG_PER_RAD_Q24 = 64'sd961263669;
  localparam longint Q28_ONE         = 64'sd268435456;
  localparam longint DEG_CLAMP       = 23040;
  localparam longint RAD_CLAMP       = 25736;
  localparam int     ATAN_ENTRIES    = 24;
  localparam int     ROTATIONS       = (CORDIC_STAGES < ATAN_ENTRIES) ?
                                       CORDIC_STAGES : ATAN_ENTRIES;
  localparam int     RANDOM_HALF     = 800;
  localparam int     CYCLE_LIMIT     = 400000;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  quat_t    quat  = '0;
  logic     busy;
  logic     done;
  heading_t heading;

  quaternion_to_heading dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .quat    (quat),
    .done    (done),
    .heading (heading)
  );

  always #1 clk = ~clk;

  quat_t    quat_pending_q[$];
  heading_t heading_exp_q[$];
  longint   atan_q30_tab[ATAN_ENTRIES];

  logic     taken      = 1'b0;
  int       burst_left = 0;
  int       gap_left   = 0;
  int       n_accepted = 0;
  int       n_checked  = 0;
  int       n_directed = 0;
  int       n_errors   = 0;
  int       n_cycles   = 0;
  heading_t exp_hd;
  heading_t got_hd;

  // atan(2^-i) in Q30, rounded to nearest
  initial begin
    for (int s = 0; s < ATAN_ENTRIES; s++)
      atan_q30_tab[s] = $rtoi($atan(2.0 ** (-s)) * 1073741824.0 + 0.5);
  end

  // v / 2^sh, rounded half away from zero
  function automatic longint round_away(longint v, int sh);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Expected heading: yaw terms, CORDIC vectoring atan2, negate, scale
  function automatic heading_t predict_heading(quat_t q);
    longint   r, qi, qj, qk;
    longint   y, x, z, dx, dy, yaw, rad, deg;
    heading_t res;
    r  = $signed(q.quat_real);
    qi = $signed(q.quat_i);
    qj = $signed(q.quat_j);
    qk = $signed(q.quat_k);
    y = 2 * (r * qk + qi * qj);
    x = Q28_ONE - 2 * (qj * qj + qk * qk);
    z = 0;
    if (x != 0 || y != 0) begin
      // left half-plane: turn the vector by a half revolution first
      if (x < 0) begin
        z = (y >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
        x = -x;
        y = -y;
      end
      for (int s = 0; s < ROTATIONS; s++) begin
        dx = y >>> s;
        dy = x >>> s;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_q30_tab[s];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_q30_tab[s];
        end
      end
    end
    yaw = -z;
    rad = clamp_sym(round_away(yaw, 17), RAD_CLAMP);
    deg = clamp_sym(round_away(yaw * DEG_PER_RAD_Q24, 47), DEG_CLAMP);
    res.heading_deg = deg[15:0];
    res.heading_rad = rad[15:0];
    return res;
  endfunction

  function automatic logic signed [15:0] to_q14(real v);
    real s;
    s = v * 16384.0;
    if (s > 32767.0) s = 32767.0;
    if (s < -32768.0) s = -32768.0;
    return 16'($rtoi(s));
  endfunction

  function automatic quat_t make_quat(int r, int qi, int qj, int qk);
    quat_t q;
    q.quat_real = 16'(r);
    q.quat_i    = 16'(qi);
    q.quat_j    = 16'(qj);
    q.quat_k    = 16'(qk);
    return q;
  endfunction

  // Random orientation, mostly well-formed unit quaternions
  function automatic quat_t random_quat();
    real   a, b, c, d, n, sc, ang;
    int    sel;
    quat_t q;
    sel = $urandom_range(0, 9);
    a = $urandom_range(0, 20000) / 10000.0 - 1.0;
    b = $urandom_range(0, 20000) / 10000.0 - 1.0;
    c = $urandom_range(0, 20000) / 10000.0 - 1.0;
    d = $urandom_range(0, 20000) / 10000.0 - 1.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 0.001) begin
      a = 1.0;
      n = 1.0;
    end
    sc = 1.0;
    if (sel == 9) sc = $urandom_range(50, 200) / 100.0;
    case (sel)
      5: begin
        // pure yaw, angles from -360 to +360 degrees
        ang = ($urandom_range(0, 72000) / 100.0 - 360.0) * 3.14159265358979 / 180.0;
        q = make_quat(to_q14($cos(ang / 2.0)), 0, 0, to_q14($sin(ang / 2.0)));
      end
      6: q = quat_t'({$urandom, $urandom});
      7: q = make_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                       $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          // near the cut at +/-180: X negative, Y tiny
          q = make_quat($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                        $urandom_range(0, 6) - 3,
                        ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(11700, 16384));
        end else begin
          // X near zero: heading close to +/-90 or degenerate
          q = make_quat($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                        8192 + $urandom_range(0, 8) - 4, 8192 + $urandom_range(0, 8) - 4);
        end
      end
      default: q = make_quat(to_q14(sc * a / n), to_q14(sc * b / n),
                             to_q14(sc * c / n), to_q14(sc * d / n));
    endcase
    return q;
  endfunction

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
          quat     <= quat_t'({$urandom, $urandom});
        end else if (quat_pending_q.size() > 0) begin
          quat  <= quat_pending_q.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
          quat  <= quat_t'({$urandom, $urandom});
        end
      end
    end
  end

  // Monitor: check results, then record accepted transactions
  always @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else begin
      if (done) begin
        got_hd = heading;
        if (heading_exp_q.size() == 0) begin
          $error("unexpected result: heading_deg %0d heading_rad %0d",
                 got_hd.heading_deg, got_hd.heading_rad);
          n_errors++;
        end else begin
          exp_hd = heading_exp_q.pop_front();
          n_checked++;
          if (got_hd.heading_deg !== exp_hd.heading_deg) begin
            $error("heading_deg: expected %0d, got %0d",
                   exp_hd.heading_deg, got_hd.heading_deg);
            n_errors++;
          end
          if (got_hd.heading_rad !== exp_hd.heading_rad) begin
            $error("heading_rad: expected %0d, got %0d",
                   exp_hd.heading_rad, got_hd.heading_rad);
            n_errors++;
          end
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        heading_exp_q.push_back(predict_heading(quat));
        n_accepted++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", n_cycles);
      $display("quaternion_to_heading_tb NOT OK");
      $finish;
    end
  end

  task automatic add_quat(int r, int qi, int qj, int qk);
    quat_pending_q.push_back(make_quat(r, qi, qj, qk));
    n_directed++;
  endtask

  // Hold until every queued transaction is accepted and answered; start is
  // stable at the rising edge, so the check cannot race the driver
  task automatic drain_all();
    while (quat_pending_q.size() != 0 || start || heading_exp_q.size() != 0)
      @(posedge clk);
  endtask

  // Sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // identity, zero quaternion, quarter turns
    add_quat(16384, 0, 0, 0);
    add_quat(0, 0, 0, 0);
    add_quat(11585, 0, 0, 11585);
    add_quat(11585, 0, 0, -11585);
    // X negative with Y zero, slightly negative, slightly positive; then X positive, Y zero
    add_quat(0, 0, 0, 16384);
    add_quat(-1, 0, 0, 16384);
    add_quat(1, 0, 0, 16384);
    add_quat(0, 0, 16384, 0);
    add_quat(0, 16384, 0, 0);
    add_quat(0, -32768, 0, 0);
    // both yaw terms exactly zero
    add_quat(5000, -5000, 8192, 8192);
    add_quat(0, 0, 8192, 8192);
    // field extremes and out-of-range parts
    add_quat(16384, 16384, 16384, 16384);
    add_quat(-16384, -16384, -16384, -16384);
    add_quat(16384, -16384, 16384, -16384);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(1, 1, 1, 1);
    add_quat(-1, -1, -1, -1);
    drain_all();

    // random traffic, with a full drain in the middle
    repeat (RANDOM_HALF) quat_pending_q.push_back(random_quat());
    drain_all();
    repeat (RANDOM_HALF) quat_pending_q.push_back(random_quat());
    drain_all();

    // catch any stray strobe after the pipeline empties
    repeat (LATENCY + 4) @(negedge clk);

    $display("ran %0d quaternions (%0d directed: degenerate, half-turn and extreme parts)",
             n_accepted, n_directed);
    $display("checked %0d headings in degrees and radians, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0) begin
      $display("quaternion_to_heading_tb OK");
    end else begin
      $display("quaternion_to_heading_tb NOT OK");
    end
    $finish;
  end

endmodule
